@@ hdl/frame_bump_allocator_resize_policy_assert.svh @@
// Assertion macros shared by the frame bump allocator RTL.
`ifndef FRAME_BUMP_ALLOCATOR_RESIZE_POLICY_ASSERT_SVH
`define FRAME_BUMP_ALLOCATOR_RESIZE_POLICY_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FBAR_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("fbar: invariant violated");
`define FBAR_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fbar: implication violated");
`define FBAR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fbar: next-cycle check violated");
`else
`define FBAR_ASSERT_ALWAYS(lbl, expr)
`define FBAR_ASSERT_IMPLIES(lbl, ante, cons)
`define FBAR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/fbar_pkg.sv @@
// Shared types and constants of the frame bump allocator.
`timescale 1ns / 1ps
package fbar_pkg;

   localparam int PAGE_SHIFT    = 12;
   localparam int BYTES_W       = 31;
   localparam int PAGES_W       = 19;
   localparam int Q8_W          = 9;
   localparam int Q8_SHIFT      = 8;
   localparam int CNT_W         = 16;
   localparam int TOTAL_ALLOC_W = 32;
   localparam int TOTAL_BYTES_W = 48;
   localparam int ALIGN_W       = 4;
   localparam int ALIGN_MASK_W  = 16;
   localparam int EVENT_W       = 2;
   localparam int CSR_IDX_W     = 3;

   localparam int INIT_PAGES_RST  = 256;
   localparam int MIN_PAGES_RST   = 16;
   localparam int GROW_Q8_RST     = 230;
   localparam int SHRINK_Q8_RST   = 64;
   localparam int GROW_NEEDED_RST = 3;
   localparam int GROW_CD_RST     = 10;
   localparam int SHRINK_CD_RST   = 60;

   localparam logic CMD_ALLOC     = 1'b0;
   localparam logic CMD_FRAME_END = 1'b1;

   localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_GREW   = 2'd1;
   localparam logic [EVENT_W-1:0] EV_SHRANK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SIZE_PAGES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIZE_PAGES     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_USAGE_Q8      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_USAGE_Q8    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_FRAMES_NEEDED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIZE_COOLDOWN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_COOLDOWN    = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_FRAME0,
      ST_FRAME1,
      ST_SCAN,
      ST_RESP
   } fsm_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scan_status_type;

endpackage

@@ hdl/fbar_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fbar_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fbar_peak_scan.sv @@
// Sequential maximum search over the filled entries of the usage window RAM.
`timescale 1ns / 1ps
module fbar_peak_scan #(
   parameter int DEPTH = 16,
   parameter int DW    = 31
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [$clog2(DEPTH + 1)-1:0]               fill,
   output logic                                       rd_en,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  logic [DW-1:0]                              rd_data,
   output fbar_pkg::scan_status_type                  status,
   output logic [DW-1:0]                              peak
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic          busy_ff, busy_in;
   logic          pend_ff, pend_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [DW-1:0] peak_ff, peak_in;
   logic          done;

   // Reads are issued at entries 0 .. fill-1; each word lands in the cycle after its read.
   assign done = busy_ff && (idx_ff >= fill) && !pend_ff;

   always_comb begin
      busy_in = busy_ff;
      pend_in = pend_ff;
      idx_in  = idx_ff;
      peak_in = peak_ff;
      rd_en   = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         pend_in = 1'b0;
         idx_in  = '0;
         peak_in = '0;
      end else if (busy_ff) begin
         if (pend_ff && (rd_data > peak_ff)) begin
            peak_in = rd_data;
         end
         if (idx_ff < fill) begin
            rd_en   = 1'b1;
            idx_in  = idx_ff + 1'b1;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      peak_ff <= peak_in;
   end

   assign rd_addr     = idx_ff[AW-1:0];
   assign status.busy = busy_ff;
   assign status.done = done;
   assign peak        = peak_ff;

endmodule

@@ hdl/frame_bump_allocator_resize_policy.sv @@
// Top level of the frame bump allocator with its grow and shrink sizing policy.
// Usage: the req_ channel carries one command beat (allocate or end of frame), the
// rsp_ channel returns exactly one result beat for each command, in order. A beat
// moves on a rising edge where valid is high and stall is low on that channel.
// An allocate beat aligns the bump offset as it is accepted, then the ALLOC state
// adds the size, checks the pool end and updates the counters, and the RESP state
// loads the result register; the next command is taken no earlier than that load.
// An end-of-frame beat writes the frame's usage into the window RAM, compares
// it against the Q8 thresholds in the cycle after the registered multiplies, and
// applies the grow rule. When the shrink rule is armed, the peak search reads the
// filled window entries one per cycle through the RAM's single read port before
// the result is loaded.
// Results sit in an output register; while rsp_stall holds a beat there, the
// block finishes the next command's work and then waits in front of that
// register, with req_stall high, until it frees up.
// Reset is synchronous: the pool comes back at 256 pages (clamped to the maximum),
// all counters clear and the window reads as empty. The window RAM is not
// cleared; only entries written since the last resize are ever read.
// Configuration writes take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
`include "frame_bump_allocator_resize_policy_assert.svh"
module frame_bump_allocator_resize_policy #(
   parameter int USAGE_WINDOW   = 16,
   parameter int MAX_POOL_PAGES = 262144
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // command channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_cmd,
   input  logic [fbar_pkg::BYTES_W-1:0]             req_alloc_bytes,
   input  logic [fbar_pkg::ALIGN_W-1:0]             req_align_log2,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_alloc_ok,
   output logic [fbar_pkg::BYTES_W-1:0]             rsp_alloc_offset,
   output logic [fbar_pkg::BYTES_W-1:0]             rsp_bytes_used,
   output logic [fbar_pkg::BYTES_W-1:0]             rsp_bytes_remaining,
   output logic [fbar_pkg::BYTES_W-1:0]             rsp_pool_bytes,
   output logic [fbar_pkg::EVENT_W-1:0]             rsp_resize_event,
   output logic [fbar_pkg::BYTES_W-1:0]             rsp_peak_bytes_used,
   output logic [fbar_pkg::TOTAL_ALLOC_W-1:0]       rsp_total_allocations,
   output logic [fbar_pkg::TOTAL_BYTES_W-1:0]       rsp_total_bytes_allocated,
   output logic [fbar_pkg::CNT_W-1:0]               rsp_resize_count,
   // configuration write port
   input  logic                                     csr_we,
   input  logic [fbar_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [fbar_pkg::PAGES_W-1:0]             csr_wdata
);

   // Widths that follow from the parameters.
   localparam int PW  = $clog2(MAX_POOL_PAGES + 1);
   localparam int PBW = PW + fbar_pkg::PAGE_SHIFT;
   localparam int SW  = ((PBW > fbar_pkg::BYTES_W) ? PBW : fbar_pkg::BYTES_W) + 2;
   localparam int PRW = fbar_pkg::Q8_W + PW;
   localparam int TSH = fbar_pkg::PAGE_SHIFT - fbar_pkg::Q8_SHIFT;
   localparam int TW  = PRW + TSH;
   localparam int MW  = ((PW + 1) > fbar_pkg::PAGES_W) ? (PW + 1) : fbar_pkg::PAGES_W;
   localparam int CLW = (PW > fbar_pkg::PAGES_W) ? PW : fbar_pkg::PAGES_W;
   localparam int AW  = (USAGE_WINDOW > 1) ? $clog2(USAGE_WINDOW) : 1;
   localparam int FW  = $clog2(USAGE_WINDOW + 1);
   localparam int RST_PAGES = (MAX_POOL_PAGES < fbar_pkg::INIT_PAGES_RST) ?
                              MAX_POOL_PAGES : fbar_pkg::INIT_PAGES_RST;

   function automatic logic [fbar_pkg::CNT_W-1:0] sat_inc16(
      input logic [fbar_pkg::CNT_W-1:0] v
   );
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Sequencer and per-command working registers.
   fbar_pkg::fsm_state_type state_ff, state_in;
   logic                           cmd_ff, cmd_in;
   logic [fbar_pkg::BYTES_W-1:0]   size_ff, size_in;
   logic [SW-1:0]                  aligned_ff, aligned_in;
   logic [PBW-1:0]                 used_ff, used_in;
   logic [PRW-1:0]                 grow_prod_ff, grow_prod_in;
   logic [PRW-1:0]                 shrink_prod_ff, shrink_prod_in;
   logic [fbar_pkg::EVENT_W-1:0]   event_ff, event_in;
   logic                           ok_ff, ok_in;
   logic [fbar_pkg::BYTES_W-1:0]   offset_ff, offset_in;

   // Allocator and policy state.
   logic [PBW-1:0]                     bump_offset_ff, bump_offset_in;
   logic [PW-1:0]                      pool_pages_ff, pool_pages_in;
   logic [fbar_pkg::CNT_W-1:0]         fsr_ff, fsr_in;
   logic [fbar_pkg::CNT_W-1:0]         over_run_ff, over_run_in;
   logic [fbar_pkg::CNT_W-1:0]         under_run_ff, under_run_in;
   logic [FW-1:0]                      fill_ff, fill_in;
   logic [AW-1:0]                      head_ff, head_in;
   logic [PBW-1:0]                     peak_used_ff, peak_used_in;
   logic [fbar_pkg::TOTAL_ALLOC_W-1:0] alloc_total_ff, alloc_total_in;
   logic [fbar_pkg::TOTAL_BYTES_W-1:0] bytes_total_ff, bytes_total_in;
   logic [fbar_pkg::CNT_W-1:0]         resizes_ff, resizes_in;

   // Configuration registers.
   logic [fbar_pkg::PAGES_W-1:0] min_pages_ff, min_pages_in;
   logic [fbar_pkg::Q8_W-1:0]    grow_q8_ff, grow_q8_in;
   logic [fbar_pkg::Q8_W-1:0]    shrink_q8_ff, shrink_q8_in;
   logic [fbar_pkg::CNT_W-1:0]   grow_needed_ff, grow_needed_in;
   logic [fbar_pkg::CNT_W-1:0]   grow_cd_ff, grow_cd_in;
   logic [fbar_pkg::CNT_W-1:0]   shrink_cd_ff, shrink_cd_in;

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_ok_ff, rsp_ok_in;
   logic [fbar_pkg::BYTES_W-1:0]       rsp_offset_ff, rsp_offset_in;
   logic [fbar_pkg::BYTES_W-1:0]       rsp_used_ff, rsp_used_in;
   logic [fbar_pkg::BYTES_W-1:0]       rsp_remain_ff, rsp_remain_in;
   logic [fbar_pkg::BYTES_W-1:0]       rsp_pool_ff, rsp_pool_in;
   logic [fbar_pkg::EVENT_W-1:0]       rsp_event_ff, rsp_event_in;
   logic [fbar_pkg::BYTES_W-1:0]       rsp_peak_ff, rsp_peak_in;
   logic [fbar_pkg::TOTAL_ALLOC_W-1:0] rsp_allocs_ff, rsp_allocs_in;
   logic [fbar_pkg::TOTAL_BYTES_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic [fbar_pkg::CNT_W-1:0]         rsp_resizes_ff, rsp_resizes_in;

   // Combinational helpers.
   logic                              out_load;
   logic                              req_fire;
   logic [PBW-1:0]                    pool_b;
   logic [fbar_pkg::ALIGN_MASK_W-1:0] align_mask;
   logic [SW-1:0]                     aligned_calc;
   logic [SW-1:0]                     end_calc;
   logic                              alloc_fit;
   logic [fbar_pkg::TOTAL_BYTES_W:0]  bytes_sum;
   logic [TW-1:0]                     grow_thr;
   logic [TW-1:0]                     shrink_thr;
   logic                              used_over;
   logic                              used_under;
   logic [PW:0]                       pages_dbl;
   logic [PW-1:0]                     pages_half;
   logic [CLW-1:0]                    csr_pages_w;
   logic [PW-1:0]                     csr_pages_clamped;

   // Window RAM and peak search.
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   logic [PBW-1:0]            ram_wr_data;
   logic                      ram_rd_en;
   logic [AW-1:0]             ram_rd_addr;
   logic [PBW-1:0]            ram_rd_data;
   logic                      scan_start;
   fbar_pkg::scan_status_type scan_status;
   logic [PBW-1:0]            scan_peak;

   fbar_ram #(
      .WIDTH (PBW),
      .DEPTH (USAGE_WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fbar_peak_scan #(
      .DEPTH (USAGE_WINDOW),
      .DW    (PBW)
   ) u_peak_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .fill    (fill_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .status  (scan_status),
      .peak    (scan_peak)
   );

   // The result register takes a new beat when it is empty or being drained.
   assign out_load  = (state_ff == fbar_pkg::ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == fbar_pkg::ST_IDLE) || out_load);
   assign req_fire  = req_valid && !req_stall;

   assign pool_b = PBW'(pool_pages_ff) << fbar_pkg::PAGE_SHIFT;

   // Alignment is done on the way in, from the offset that the last beat left.
   assign align_mask   = fbar_pkg::ALIGN_MASK_W'((17'd1 << req_align_log2) - 17'd1);
   assign aligned_calc = (SW'(bump_offset_ff) + SW'(align_mask)) & ~SW'(align_mask);

   assign end_calc  = aligned_ff + SW'(size_ff);
   assign alloc_fit = end_calc <= SW'(pool_b);
   assign bytes_sum = (fbar_pkg::TOTAL_BYTES_W + 1)'(bytes_total_ff)
                    + (fbar_pkg::TOTAL_BYTES_W + 1)'(size_ff);

   // used*256 against q8*pages*4096 reduces to used against q8*pages*16.
   assign grow_thr   = TW'(grow_prod_ff) << TSH;
   assign shrink_thr = TW'(shrink_prod_ff) << TSH;
   assign used_over  = TW'(used_ff) > grow_thr;
   assign used_under = TW'(used_ff) < shrink_thr;

   assign pages_dbl  = (PW + 1)'(pool_pages_ff) << 1;
   assign pages_half = PW'(((PW + 1)'(pool_pages_ff) + 1'b1) >> 1);

   // A write of the initial size reloads the pool, clamped to 1 .. maximum.
   assign csr_pages_w = CLW'(csr_wdata);
   always_comb begin
      priority if (csr_pages_w == '0) begin
         csr_pages_clamped = PW'(1);
      end else if (csr_pages_w > CLW'(MAX_POOL_PAGES)) begin
         csr_pages_clamped = PW'(MAX_POOL_PAGES);
      end else begin
         csr_pages_clamped = PW'(csr_pages_w);
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      size_in        = size_ff;
      aligned_in     = aligned_ff;
      used_in        = used_ff;
      grow_prod_in   = grow_prod_ff;
      shrink_prod_in = shrink_prod_ff;
      event_in       = event_ff;
      ok_in          = ok_ff;
      offset_in      = offset_ff;
      bump_offset_in = bump_offset_ff;
      pool_pages_in  = pool_pages_ff;
      fsr_in         = fsr_ff;
      over_run_in    = over_run_ff;
      under_run_in   = under_run_ff;
      fill_in        = fill_ff;
      head_in        = head_ff;
      peak_used_in   = peak_used_ff;
      alloc_total_in = alloc_total_ff;
      bytes_total_in = bytes_total_ff;
      resizes_in     = resizes_ff;
      min_pages_in   = min_pages_ff;
      grow_q8_in     = grow_q8_ff;
      shrink_q8_in   = shrink_q8_ff;
      grow_needed_in = grow_needed_ff;
      grow_cd_in     = grow_cd_ff;
      shrink_cd_in   = shrink_cd_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ok_in      = rsp_ok_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_remain_in  = rsp_remain_ff;
      rsp_pool_in    = rsp_pool_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_peak_in    = rsp_peak_ff;
      rsp_allocs_in  = rsp_allocs_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_resizes_in = rsp_resizes_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = head_ff;
      ram_wr_data    = bump_offset_ff;
      scan_start     = 1'b0;

      unique case (state_ff)
         fbar_pkg::ST_IDLE: begin
         end
         fbar_pkg::ST_ALLOC: begin
            event_in = fbar_pkg::EV_NONE;
            if (alloc_fit) begin
               ok_in          = 1'b1;
               offset_in      = fbar_pkg::BYTES_W'(aligned_ff);
               bump_offset_in = PBW'(end_calc);
               if (end_calc > SW'(peak_used_ff)) begin
                  peak_used_in = PBW'(end_calc);
               end
               if (alloc_total_ff != '1) begin
                  alloc_total_in = alloc_total_ff + 1'b1;
               end
               bytes_total_in = bytes_sum[fbar_pkg::TOTAL_BYTES_W] ? '1 :
                                bytes_sum[fbar_pkg::TOTAL_BYTES_W-1:0];
            end else begin
               ok_in     = 1'b0;
               offset_in = '0;
            end
            state_in = fbar_pkg::ST_RESP;
         end
         fbar_pkg::ST_FRAME0: begin
            // Record the frame's usage and start the threshold products.
            ok_in          = 1'b0;
            offset_in      = '0;
            event_in       = fbar_pkg::EV_NONE;
            used_in        = bump_offset_ff;
            bump_offset_in = '0;
            fsr_in         = sat_inc16(fsr_ff);
            ram_wr_en      = 1'b1;
            head_in        = (head_ff == AW'(USAGE_WINDOW - 1)) ? '0 : head_ff + 1'b1;
            if (fill_ff < FW'(USAGE_WINDOW)) begin
               fill_in = fill_ff + 1'b1;
            end
            grow_prod_in   = PRW'(grow_q8_ff) * PRW'(pool_pages_ff);
            shrink_prod_in = PRW'(shrink_q8_ff) * PRW'(pool_pages_ff);
            state_in       = fbar_pkg::ST_FRAME1;
         end
         fbar_pkg::ST_FRAME1: begin
            priority if (used_over) begin
               over_run_in  = sat_inc16(over_run_ff);
               under_run_in = '0;
            end else if (used_under) begin
               under_run_in = sat_inc16(under_run_ff);
               over_run_in  = '0;
            end else begin
               over_run_in  = '0;
               under_run_in = '0;
            end
            state_in = fbar_pkg::ST_RESP;
            if (used_over && (sat_inc16(over_run_ff) >= grow_needed_ff)
                && (fsr_ff >= grow_cd_ff)
                && (pages_dbl <= (PW + 1)'(MAX_POOL_PAGES))) begin
               // Grow branch; a target below the minimum keeps the size but
               // still restarts the run, the frame count and the window.
               if (MW'(pages_dbl) >= MW'(min_pages_ff)) begin
                  pool_pages_in = PW'(pages_dbl);
                  resizes_in    = sat_inc16(resizes_ff);
                  event_in      = fbar_pkg::EV_GREW;
               end
               over_run_in = '0;
               fsr_in      = '0;
               fill_in     = '0;
               head_in     = '0;
            end else if ((fsr_ff >= shrink_cd_ff) && (fill_ff != '0)
                         && (MW'(pool_pages_ff) > MW'(min_pages_ff))) begin
               scan_start = 1'b1;
               state_in   = fbar_pkg::ST_SCAN;
            end
         end
         fbar_pkg::ST_SCAN: begin
            if (scan_status.done) begin
               if (TW'(scan_peak) < shrink_thr) begin
                  if (MW'(pages_half) >= MW'(min_pages_ff)) begin
                     pool_pages_in = pages_half;
                     resizes_in    = sat_inc16(resizes_ff);
                     event_in      = fbar_pkg::EV_SHRANK;
                  end
                  under_run_in = '0;
                  fsr_in       = '0;
                  fill_in      = '0;
                  head_in      = '0;
               end
               state_in = fbar_pkg::ST_RESP;
            end
         end
         fbar_pkg::ST_RESP: begin
            if (out_load) begin
               state_in = fbar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbar_pkg::ST_IDLE;
         end
      endcase

      // The result is built from the state that the finished command left.
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = ok_ff;
         rsp_offset_in  = offset_ff;
         rsp_used_in    = fbar_pkg::BYTES_W'(bump_offset_ff);
         rsp_remain_in  = (pool_b > bump_offset_ff) ?
                          fbar_pkg::BYTES_W'(pool_b - bump_offset_ff) : '0;
         rsp_pool_in    = fbar_pkg::BYTES_W'(pool_b);
         rsp_event_in   = event_ff;
         rsp_peak_in    = fbar_pkg::BYTES_W'(peak_used_ff);
         rsp_allocs_in  = alloc_total_ff;
         rsp_bytes_in   = bytes_total_ff;
         rsp_resizes_in = resizes_ff;
      end

      if (req_fire) begin
         cmd_in     = req_cmd;
         size_in    = req_alloc_bytes;
         aligned_in = aligned_calc;
         state_in   = (req_cmd == fbar_pkg::CMD_FRAME_END) ?
                      fbar_pkg::ST_FRAME0 : fbar_pkg::ST_ALLOC;
      end

      if (csr_we) begin
         unique case (csr_index)
            fbar_pkg::CSR_INITIAL_SIZE_PAGES: pool_pages_in  = csr_pages_clamped;
            fbar_pkg::CSR_MIN_SIZE_PAGES:     min_pages_in   = csr_wdata;
            fbar_pkg::CSR_GROW_USAGE_Q8:      grow_q8_in     = csr_wdata[fbar_pkg::Q8_W-1:0];
            fbar_pkg::CSR_SHRINK_USAGE_Q8:    shrink_q8_in   = csr_wdata[fbar_pkg::Q8_W-1:0];
            fbar_pkg::CSR_GROW_FRAMES_NEEDED: grow_needed_in = csr_wdata[fbar_pkg::CNT_W-1:0];
            fbar_pkg::CSR_RESIZE_COOLDOWN:    grow_cd_in     = csr_wdata[fbar_pkg::CNT_W-1:0];
            fbar_pkg::CSR_SHRINK_COOLDOWN:    shrink_cd_in   = csr_wdata[fbar_pkg::CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fbar_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         bump_offset_ff <= '0;
         pool_pages_ff  <= PW'(RST_PAGES);
         fsr_ff         <= '0;
         over_run_ff    <= '0;
         under_run_ff   <= '0;
         fill_ff        <= '0;
         head_ff        <= '0;
         peak_used_ff   <= '0;
         alloc_total_ff <= '0;
         bytes_total_ff <= '0;
         resizes_ff     <= '0;
         min_pages_ff   <= fbar_pkg::PAGES_W'(fbar_pkg::MIN_PAGES_RST);
         grow_q8_ff     <= fbar_pkg::Q8_W'(fbar_pkg::GROW_Q8_RST);
         shrink_q8_ff   <= fbar_pkg::Q8_W'(fbar_pkg::SHRINK_Q8_RST);
         grow_needed_ff <= fbar_pkg::CNT_W'(fbar_pkg::GROW_NEEDED_RST);
         grow_cd_ff     <= fbar_pkg::CNT_W'(fbar_pkg::GROW_CD_RST);
         shrink_cd_ff   <= fbar_pkg::CNT_W'(fbar_pkg::SHRINK_CD_RST);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         bump_offset_ff <= bump_offset_in;
         pool_pages_ff  <= pool_pages_in;
         fsr_ff         <= fsr_in;
         over_run_ff    <= over_run_in;
         under_run_ff   <= under_run_in;
         fill_ff        <= fill_in;
         head_ff        <= head_in;
         peak_used_ff   <= peak_used_in;
         alloc_total_ff <= alloc_total_in;
         bytes_total_ff <= bytes_total_in;
         resizes_ff     <= resizes_in;
         min_pages_ff   <= min_pages_in;
         grow_q8_ff     <= grow_q8_in;
         shrink_q8_ff   <= shrink_q8_in;
         grow_needed_ff <= grow_needed_in;
         grow_cd_ff     <= grow_cd_in;
         shrink_cd_ff   <= shrink_cd_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      size_ff        <= size_in;
      aligned_ff     <= aligned_in;
      used_ff        <= used_in;
      grow_prod_ff   <= grow_prod_in;
      shrink_prod_ff <= shrink_prod_in;
      event_ff       <= event_in;
      ok_ff          <= ok_in;
      offset_ff      <= offset_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_remain_ff  <= rsp_remain_in;
      rsp_pool_ff    <= rsp_pool_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_allocs_ff  <= rsp_allocs_in;
      rsp_bytes_ff   <= rsp_bytes_in;
      rsp_resizes_ff <= rsp_resizes_in;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_alloc_ok              = rsp_ok_ff;
   assign rsp_alloc_offset          = rsp_offset_ff;
   assign rsp_bytes_used            = rsp_used_ff;
   assign rsp_bytes_remaining       = rsp_remain_ff;
   assign rsp_pool_bytes            = rsp_pool_ff;
   assign rsp_resize_event          = rsp_event_ff;
   assign rsp_peak_bytes_used       = rsp_peak_ff;
   assign rsp_total_allocations     = rsp_allocs_ff;
   assign rsp_total_bytes_allocated = rsp_bytes_ff;
   assign rsp_resize_count          = rsp_resizes_ff;

   // The peak search only runs while the sequencer waits for it.
   `FBAR_ASSERT_IMPLIES(a_scan_in_state, scan_status.busy, state_ff == fbar_pkg::ST_SCAN)
   // A resize is only ever reported on an end-of-frame beat.
   `FBAR_ASSERT_IMPLIES(a_event_not_alloc, rsp_valid && (rsp_resize_event != fbar_pkg::EV_NONE), !rsp_alloc_ok)
   // The window never claims more entries than the RAM holds.
   `FBAR_ASSERT_ALWAYS(a_fill_bound, fill_ff <= FW'(USAGE_WINDOW))
   // A granted block never moves the offset past the pool end.
   `FBAR_ASSERT_NEXT(a_alloc_fits, (state_ff == fbar_pkg::ST_ALLOC) && alloc_fit && !csr_we, bump_offset_ff <= pool_b)

endmodule
